### rtl/rceu_pkg.sv
// ----------------------------------------------------------------------------
// rceu_pkg
// Shared types and codes for the replay clock event update unit.
// ----------------------------------------------------------------------------
package rceu_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;
    localparam int EPOCH_W     = 32;
    localparam int OWN_W       = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_BOUND = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_PROCESS  = 4'd1;

    typedef enum logic [1:0] {
        CMD_SEND = 2'd0,
        CMD_RECV = 2'd1,
        CMD_TICK = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic epoch_held;
        logic self_at_top;
        logic msg_at_top;
    } ctrl_t;

    typedef struct packed {
        logic is_own;
        logic own_keep;
        logic eq_self;
        logic eq_msg;
    } lane_flags_t;

endpackage

### rtl/rceu_lane.sv
// ----------------------------------------------------------------------------
// rceu_lane
// Per-process offset update: epoch shift, clamp, merge by minimum and the
// equality flags used by the counter merge.
// ----------------------------------------------------------------------------
module rceu_lane
    import rceu_pkg::*;
#(
    parameter int OFFSET_BITS = 8
)
(
    input  ctrl_t                  ctrl,
    input  logic [EPOCH_W-1:0]     old_ep,
    input  logic [EPOCH_W-1:0]     self_ep,
    input  logic [EPOCH_W-1:0]     msg_new_ep,
    input  logic [EPOCH_W-1:0]     msg_ep,
    input  logic [EPOCH_W-1:0]     noff,
    input  logic [OFFSET_BITS-1:0] bound,
    input  logic [OFFSET_BITS-1:0] off_q,
    input  logic [OFFSET_BITS-1:0] moff,
    input  logic                   is_own,
    output logic [OFFSET_BITS-1:0] off_next,
    output lane_flags_t            flags
);

    function automatic logic [OFFSET_BITS-1:0] clamp_off(
        input logic [EPOCH_W+1:0]     d,
        input logic [OFFSET_BITS-1:0] b
    );
        if (d[EPOCH_W+1])
            return '0;
        else if (d[EPOCH_W:0] > (EPOCH_W+1)'(b))
            return b;
        else
            return d[OFFSET_BITS-1:0];
    endfunction

    logic [EPOCH_W+1:0]     self_sum;
    logic [EPOCH_W+1:0]     msg_sum;
    logic [OFFSET_BITS-1:0] self_shift;
    logic [OFFSET_BITS-1:0] msg_shift;
    logic [OFFSET_BITS-1:0] merged;

    assign self_sum   = {2'b00, self_ep} - {2'b00, old_ep} + (EPOCH_W+2)'(off_q);
    assign msg_sum    = {2'b00, msg_new_ep} - {2'b00, msg_ep} + (EPOCH_W+2)'(moff);
    assign self_shift = clamp_off(self_sum, bound);
    assign msg_shift  = clamp_off(msg_sum, bound);
    assign merged     = (msg_shift < self_shift) ? msg_shift : self_shift;

    assign flags.is_own   = is_own;
    assign flags.own_keep = is_own && (EPOCH_W'(off_q) <= noff);
    assign flags.eq_self  = (off_q == merged);
    assign flags.eq_msg   = (moff == merged);

    always_comb
    begin
        case (ctrl.cmd)
            CMD_SEND:
            begin
                if (ctrl.epoch_held)
                    off_next = (is_own && (noff < EPOCH_W'(off_q))) ?
                               noff[OFFSET_BITS-1:0] : off_q;
                else
                    off_next = is_own ? '0 : self_shift;
            end
            CMD_RECV:
                off_next = merged;
            CMD_TICK:
                off_next = is_own ? '0 : self_shift;
            default:
                off_next = off_q;
        endcase
    end

endmodule

### rtl/rceu_merge.sv
// ----------------------------------------------------------------------------
// rceu_merge
// Combines the lane flags and selects, bumps or clears the counters.
// ----------------------------------------------------------------------------
module rceu_merge
    import rceu_pkg::*;
#(
    parameter int NUM_PROCS    = 4,
    parameter int COUNTER_BITS = 16
)
(
    input  ctrl_t                   ctrl,
    input  lane_flags_t             flags    [NUM_PROCS],
    input  logic [COUNTER_BITS-1:0] cnt_q    [NUM_PROCS],
    input  logic [COUNTER_BITS-1:0] mcnt     [NUM_PROCS],
    output logic [COUNTER_BITS-1:0] cnt_next [NUM_PROCS]
);

    function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] c);
        return (&c) ? c : c + COUNTER_BITS'(1);
    endfunction

    logic own_keep;
    logic all_self;
    logic all_msg;
    logic self_eq;
    logic msg_eq;

    always_comb
    begin
        own_keep = 1'b0;
        all_self = 1'b1;
        all_msg  = 1'b1;
        for (int i = 0; i < NUM_PROCS; i++)
        begin
            own_keep = own_keep | flags[i].own_keep;
            all_self = all_self & flags[i].eq_self;
            all_msg  = all_msg & flags[i].eq_msg;
        end
        self_eq = ctrl.self_at_top && all_self;
        msg_eq  = ctrl.msg_at_top && all_msg;
    end

    always_comb
    begin
        logic [COUNTER_BITS-1:0] sel;
        for (int i = 0; i < NUM_PROCS; i++)
        begin
            sel = '0;
            case (ctrl.cmd)
                CMD_SEND:
                begin
                    if (ctrl.epoch_held && own_keep)
                        cnt_next[i] = flags[i].is_own ? sat_inc(cnt_q[i]) : cnt_q[i];
                    else
                        cnt_next[i] = '0;
                end
                CMD_RECV:
                begin
                    if (self_eq && msg_eq)
                        sel = (cnt_q[i] > mcnt[i]) ? cnt_q[i] : mcnt[i];
                    else if (self_eq)
                        sel = cnt_q[i];
                    else if (msg_eq)
                        sel = mcnt[i];
                    cnt_next[i] = (flags[i].is_own && (self_eq || msg_eq)) ?
                                  sat_inc(sel) : sel;
                end
                default:
                    cnt_next[i] = cnt_q[i];
            endcase
        end
    end

endmodule

### rtl/replay_clock_event_update_unit.sv
// ----------------------------------------------------------------------------
// replay_clock_event_update_unit
// Replay clock of one process: epoch, bounded offsets and counters.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one event per transaction. s_tuser carries the event kind
//   (send/local, receive, tick); s_tdata carries the physical epoch and the
//   packed message clock.
//   Master stream: one transaction per event with the whole clock after it.
//   Config channel: cfg_index selects offset_bound (0) or own_process (1);
//   cfg_ready is always high. Write only while the unit is idle.
// Timing:
//   The result is in the output register the cycle after the event is taken.
//   Throughput is 1 event per cycle while m_tready is high; the clock update
//   of all lanes and the counter merge fit in the single state feedback loop.
//   The next event is taken while a result waits, as long as the receiver
//   takes that result in the same cycle.
// Reset:
//   Epoch 0, offsets all ones, counters zero, offset_bound 255,
//   own_process 0, output empty.
// Stall:
//   With m_tready low the result holds and s_tready drops until it is taken.
// ----------------------------------------------------------------------------
module replay_clock_event_update_unit
    import rceu_pkg::*;
#(
    parameter int NUM_PROCS    = 4,
    parameter int OFFSET_BITS  = 8,
    parameter int COUNTER_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // phys_epoch, msg_epoch, msg_offsets, msg_counters
    input  logic [159:0]           s_tdata,
    // cmd
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // clock_epoch, clock_offsets, clock_counters
    output logic [127:0]           m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    logic [CFG_DATA_W-1:0]   offset_bound_reg;
    logic [OWN_W-1:0]        own_process_reg;
    logic [EPOCH_W-1:0]      epoch_reg;
    logic [EPOCH_W-1:0]      epoch_next;
    logic [OFFSET_BITS-1:0]  offset_reg   [NUM_PROCS];
    logic [OFFSET_BITS-1:0]  offset_next  [NUM_PROCS];
    logic [COUNTER_BITS-1:0] counter_reg  [NUM_PROCS];
    logic [COUNTER_BITS-1:0] counter_next [NUM_PROCS];
    logic                    out_valid_reg;
    logic [127:0]            out_data_reg;
    logic [127:0]            out_data_next;

    logic [EPOCH_W-1:0]      phys;
    logic [EPOCH_W-1:0]      mep;
    logic [EPOCH_W-1:0]      ne_send;
    logic [EPOCH_W-1:0]      ne_ab;
    logic [EPOCH_W-1:0]      ne_recv;
    logic [EPOCH_W-1:0]      noff;
    logic [EPOCH_W-1:0]      self_ep;
    logic [OFFSET_BITS-1:0]  bound;
    logic [OFFSET_BITS-1:0]  moff [NUM_PROCS];
    logic [COUNTER_BITS-1:0] mcnt [NUM_PROCS];
    lane_flags_t             flags [NUM_PROCS];
    ctrl_t                   ctrl;
    logic                    accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign phys    = s_tdata[31:0];
    assign mep     = s_tdata[63:32];
    assign ne_send = (epoch_reg > phys) ? epoch_reg : phys;
    assign ne_ab   = (epoch_reg > mep) ? epoch_reg : mep;
    assign ne_recv = (ne_ab > phys) ? ne_ab : phys;
    assign noff    = ne_send - phys;
    assign bound   = (offset_bound_reg > CFG_DATA_W'(OFF_MAX)) ?
                     OFF_MAX : offset_bound_reg[OFFSET_BITS-1:0];

    assign ctrl.cmd         = cmd_t'(s_tuser);
    assign ctrl.epoch_held  = (ne_send == epoch_reg);
    assign ctrl.self_at_top = (epoch_reg == ne_recv);
    assign ctrl.msg_at_top  = (mep == ne_recv);

    always_comb
    begin
        case (ctrl.cmd)
            CMD_SEND:
            begin
                self_ep    = ne_send;
                epoch_next = ne_send;
            end
            CMD_RECV:
            begin
                self_ep    = ne_recv;
                epoch_next = ne_recv;
            end
            CMD_TICK:
            begin
                self_ep    = phys;
                epoch_next = phys;
            end
            default:
            begin
                self_ep    = epoch_reg;
                epoch_next = epoch_reg;
            end
        endcase
    end

    for (genvar i = 0; i < NUM_PROCS; i++)
    begin : g_lane
        assign moff[i] = s_tdata[64 + 8*i +: OFFSET_BITS];
        assign mcnt[i] = s_tdata[96 + 16*i +: COUNTER_BITS];

        rceu_lane #(
            .OFFSET_BITS (OFFSET_BITS)
        ) u_lane (
            .ctrl       (ctrl),
            .old_ep     (epoch_reg),
            .self_ep    (self_ep),
            .msg_new_ep (ne_recv),
            .msg_ep     (mep),
            .noff       (noff),
            .bound      (bound),
            .off_q      (offset_reg[i]),
            .moff       (moff[i]),
            .is_own     ({1'b0, own_process_reg} == (OWN_W+1)'(i)),
            .off_next   (offset_next[i]),
            .flags      (flags[i])
        );
    end

    rceu_merge #(
        .NUM_PROCS    (NUM_PROCS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_merge (
        .ctrl     (ctrl),
        .flags    (flags),
        .cnt_q    (counter_reg),
        .mcnt     (mcnt),
        .cnt_next (counter_next)
    );

    always_comb
    begin
        out_data_next        = '0;
        out_data_next[31:0]  = epoch_next;
        for (int i = 0; i < NUM_PROCS; i++)
        begin
            out_data_next[32 + 8*i +: 8]  = 8'(offset_next[i]);
            out_data_next[64 + 16*i +: 16] = 16'(counter_next[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bound_reg <= 8'd255;
            own_process_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OFFSET_BOUND: offset_bound_reg <= cfg_data;
                REG_OWN_PROCESS:  own_process_reg  <= cfg_data[OWN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= '0;
            for (int i = 0; i < NUM_PROCS; i++)
            begin
                offset_reg[i]  <= '1;
                counter_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            epoch_reg   <= epoch_next;
            offset_reg  <= offset_next;
            counter_reg <= counter_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

endmodule

### rtl/rceu_checker.sv
// ----------------------------------------------------------------------------
// rceu_checker
// Port-level checks for the replay clock event update unit.
// ----------------------------------------------------------------------------
module rceu_checker
    import rceu_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [159:0] s_tdata,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    a_ready_follows_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow output register state");

    a_result_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
    else $error("no result after accepted transaction");

    a_stall_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

    a_tick_epoch: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == CMD_TICK)) |=>
        (m_tdata[31:0] == $past(s_tdata[31:0])))
    else $error("tick did not load the given epoch");

endmodule

bind replay_clock_event_update_unit rceu_checker u_rceu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
